FILE: rtl/core/mmp_pkg.sv
// Shared types and constants for the modular matrix product block.
package mmp_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DATA_W      = 16;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DVD_W       = PROD_W + 1;
  localparam int MOD_W       = DATA_W + 1;

  typedef enum logic [1:0] {
    MODE_WRITE_A = 2'd0,
    MODE_WRITE_B = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_MODULUS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] product_value;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [MOD_W-1:0] modulus;
  } red_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] remainder;
  } red_rsp_t;

endpackage

FILE: rtl/core/mmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mmp_modred.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module mmp_modred (
  input  logic             clk,
  input  logic             rst_n,
  input  mmp_pkg::red_req_t req,
  output mmp_pkg::red_rsp_t rsp
);
  import mmp_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MOD_W:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    if (req.start) begin
      dvd_nxt  = req.dividend;
      mod_nxt  = req.modulus;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, mod_r}) begin
        rem_nxt = MOD_W'(trial - {1'b0, mod_r});
      end else begin
        rem_nxt = trial[MOD_W-1:0];
      end
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r[DATA_W-1:0];

endmodule

FILE: rtl/core/modular_matrix_product.sv
// Modular matrix product: element stores, sequencer and shared remainder unit.
// A load transaction is taken in idle, so the block stays ready for the next one.
// A compute transaction walks the inner dimension for each element of C through the
// read, multiply, add and bit-serial remainder states, then holds it in the output state.
// Synchronous active-low reset returns to idle with the configuration registers at
// their reset values; the element stores are not cleared and must be written before use.
module modular_matrix_product #(
  parameter int MAX_DIM = mmp_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mmp_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mmp_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [mmp_pkg::DATA_W-1:0] cfg_wdata
);
  import mmp_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_ADD, S_DIV, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   rows_r, inner_r, cols_r;
  logic [DATA_W-1:0]  mod_r;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DATA_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0]  prod_r;
  out_item_t          out_r, out_nxt;
  logic [DIM_W-1:0]   nr, nk, nc;
  logic               accept_in, load_ok;
  logic               we_a, we_b;
  logic [AW-1:0]      waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0]  rdata_a, rdata_b;
  red_req_t           red_req;
  red_rsp_t           red_rsp;
  logic               last_k, last_i, last_j;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    logic [2*IDX_W+DIM_W-1:0] full;
    full = (2*IDX_W+DIM_W)'(r) * (2*IDX_W+DIM_W)'(MAX_DIM) + (2*IDX_W+DIM_W)'(c);
    return full[AW-1:0];
  endfunction

  assign nr = eff_dim(rows_r);
  assign nk = eff_dim(inner_r);
  assign nc = eff_dim(cols_r);

  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid && in_ready;
  assign load_ok   = (DIM_W'(in_data.row) < DIM_W'(MAX_DIM)) &&
                     (DIM_W'(in_data.col) < DIM_W'(MAX_DIM));
  assign we_a  = accept_in && load_ok && (in_data.mode == MODE_WRITE_A);
  assign we_b  = accept_in && load_ok && (in_data.mode == MODE_WRITE_B);
  assign waddr = addr_of(in_data.row, in_data.col);
  assign raddr_a = addr_of(i_r, k_r);
  assign raddr_b = addr_of(k_r, j_r);

  mmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(in_data.value),
    .raddr(raddr_a), .rdata(rdata_a)
  );

  mmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(in_data.value),
    .raddr(raddr_b), .rdata(rdata_b)
  );

  assign red_req.start    = (state_r == S_ADD);
  assign red_req.dividend = DVD_W'(acc_r) + DVD_W'(prod_r);
  assign red_req.modulus  = (mod_r == '0) ? MOD_W'(1 << DATA_W) : MOD_W'(mod_r);

  mmp_modred u_modred (
    .clk(clk), .rst_n(rst_n), .req(red_req), .rsp(red_rsp)
  );

  assign last_k = (DIM_W'(k_r) == nk - 1'b1);
  assign last_i = (DIM_W'(i_r) == nr - 1'b1);
  assign last_j = (DIM_W'(j_r) == nc - 1'b1);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    out_nxt   = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept_in && in_data.mode == MODE_COMPUTE) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_DIV;
      S_DIV: begin
        if (red_rsp.done) begin
          acc_nxt = red_rsp.remainder;
          if (last_k) begin
            out_nxt.product_value = red_rsp.remainder;
            out_nxt.out_row       = i_r;
            out_nxt.out_col       = j_r;
            out_nxt.last          = last_i && last_j;
            state_nxt             = S_OUT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          k_nxt   = '0;
          acc_nxt = '0;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          state_nxt = (last_i && last_j) ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_r  <= DIM_W'(1);
      inner_r <= DIM_W'(1);
      cols_r  <= DIM_W'(1);
      mod_r   <= DATA_W'(65535);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_ROWS_A:    rows_r  <= cfg_wdata[DIM_W-1:0];
          CFG_INNER_DIM: inner_r <= cfg_wdata[DIM_W-1:0];
          CFG_COLS_B:    cols_r  <= cfg_wdata[DIM_W-1:0];
          CFG_MODULUS:   mod_r   <= cfg_wdata;
          default:       mod_r   <= mod_r;
        endcase
      end
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
    prod_r <= rdata_a * rdata_b;
  end

  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

endmodule

FILE: rtl/core/mmp_checker.sv
// Port-level checker for the modular matrix product block, with its bind.
module mmp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mmp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mmp_pkg::out_item_t out_data
);
  import mmp_pkg::*;

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while a result is shown");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == MODE_COMPUTE |=> !in_ready)
    else $error("ready right after a compute transaction");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> in_ready && !out_valid)
    else $error("no return to idle after the final result");

  a_rst: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind modular_matrix_product mmp_checker u_mmp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

FILE: dv/testbench.sv
// Self-checking testbench for the modular matrix product block.
`timescale 1ns / 100ps

module testbench;
  import mmp_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
  logic [DATA_W-1:0] mod_reg;
  logic [DATA_W-1:0] a_mem [64];
  logic [DATA_W-1:0] b_mem [64];
  bit [63:0] a_set, b_set;
  out_item_t pending_c [$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_stall_pct = 71;
  dir_row_t dir_tab [$];

  modular_matrix_product dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > 8) return 8;
    return d;
  endfunction

  function automatic void predict_item(in_item_t it, bit emit);
    longint unsigned m, acc;
    int unsigned nr, nk, nc;
    out_item_t r;
    case (it.mode)
      MODE_WRITE_A: begin
        a_mem[{it.row, it.col}] = it.value;
        a_set[{it.row, it.col}] = 1'b1;
      end
      MODE_WRITE_B: begin
        b_mem[{it.row, it.col}] = it.value;
        b_set[{it.row, it.col}] = 1'b1;
      end
      MODE_COMPUTE: if (emit) begin
        m = (mod_reg == 0) ? 65536 : mod_reg;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
              acc = (acc + longint'(a_mem[i*8+k]) * longint'(b_mem[k*8+j])) % m;
            end
            r.product_value = acc[15:0];
            r.out_row = IDX_W'(i);
            r.out_col = IDX_W'(j);
            r.last = (i == nr - 1) && (j == nc - 1);
            pending_c.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_item(it, !typed);
    if (typed) pending_c.push_back(want);
    sent++;
    if (sent == 150) begin
      send_idle_pct = 71;
      recv_stall_pct = 18;
    end else if (sent == 300) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_c.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ROWS_A:    rows_reg = val[DIM_W-1:0];
      CFG_INNER_DIM: inner_reg = val[DIM_W-1:0];
      CFG_COLS_B:    cols_reg = val[DIM_W-1:0];
      default:       mod_reg = val;
    endcase
    @(negedge clk);
  endtask

  task automatic set_shape(int r, int k, int c, int m);
    drain();
    write_reg(CFG_ROWS_A, DATA_W'(r));
    write_reg(CFG_INNER_DIM, DATA_W'(k));
    write_reg(CFG_COLS_B, DATA_W'(c));
    write_reg(CFG_MODULUS, DATA_W'(m));
    cfg_we <= 1'b0;
  endtask

  // One round: random loads and noise, then every missing operand, then a compute.
  task automatic run_round();
    in_item_t it;
    int unsigned nr, nk, nc;
    nr = eff_dim(rows_reg);
    nk = eff_dim(inner_reg);
    nc = eff_dim(cols_reg);
    repeat ($urandom_range(0, 8)) begin
      it.mode = ($urandom_range(9) == 0) ? MODE_NONE :
                ($urandom_range(1) ? MODE_WRITE_A : MODE_WRITE_B);
      it.row = IDX_W'($urandom);
      it.col = IDX_W'($urandom);
      it.value = DATA_W'($urandom);
      send_item(it);
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (i < nr && j < nk && (!a_set[i*8+j] || $urandom_range(3) == 0)) begin
          it.mode = MODE_WRITE_A; it.row = IDX_W'(i); it.col = IDX_W'(j);
          it.value = DATA_W'($urandom);
          send_item(it);
        end
        if (i < nk && j < nc && (!b_set[i*8+j] || $urandom_range(3) == 0)) begin
          it.mode = MODE_WRITE_B; it.row = IDX_W'(i); it.col = IDX_W'(j);
          it.value = DATA_W'($urandom);
          send_item(it);
        end
      end
    end
    it.mode = MODE_COMPUTE;
    it.row = IDX_W'($urandom);
    it.col = IDX_W'($urandom);
    it.value = DATA_W'($urandom);
    send_item(it);
  endtask

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_c.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", out_data);
      end else begin
        want = pending_c.pop_front();
        if (out_data.product_value !== want.product_value ||
            out_data.out_row !== want.out_row || out_data.out_col !== want.out_col ||
            out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  function automatic dir_row_t mk(mode_t md, int r, int c, int v, bit typed = 0,
                                  int pv = 0);
    dir_row_t d;
    d.item.mode = md;
    d.item.row = IDX_W'(r);
    d.item.col = IDX_W'(c);
    d.item.value = DATA_W'(v);
    d.typed = typed;
    d.want = '{product_value: DATA_W'(pv), out_row: IDX_W'(0), out_col: IDX_W'(0),
               last: 1'b1};
    return d;
  endfunction

  initial begin
    rows_reg = 1;
    inner_reg = 1;
    cols_reg = 1;
    mod_reg = 16'hFFFF;
    a_set = '0;
    b_set = '0;
    dir_tab = '{
      mk(MODE_WRITE_A, 0, 0, 16'hFFFF), mk(MODE_WRITE_B, 0, 0, 16'hFFFF),
      mk(MODE_COMPUTE, 0, 0, 0, 1, 0),
      mk(MODE_NONE, 7, 7, 16'hFFFF),
      mk(MODE_WRITE_A, 0, 0, 1), mk(MODE_WRITE_B, 0, 0, 16'hFFFE),
      mk(MODE_COMPUTE, 7, 7, 16'hFFFF, 1, 16'hFFFE),
      mk(MODE_WRITE_A, 7, 7, 16'h1234), mk(MODE_WRITE_B, 7, 7, 16'hEDCB),
      mk(MODE_WRITE_A, 0, 0, 0),
      mk(MODE_COMPUTE, 0, 0, 0, 1, 0),
      mk(MODE_WRITE_A, 0, 0, 16'h00FF), mk(MODE_WRITE_B, 0, 0, 16'h0101),
      mk(MODE_COMPUTE, 0, 0, 0, 1, 0),
      mk(MODE_WRITE_A, 0, 0, 2), mk(MODE_WRITE_B, 0, 0, 3),
      mk(MODE_NONE, 0, 0, 0),
      mk(MODE_COMPUTE, 0, 0, 0)
    };
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_tab[n]) send_item(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].want);

    set_shape(8, 8, 8, 0);
    run_round();
    set_shape(2, 3, 2, 1);
    run_round();
    set_shape(0, 15, 3, 2);
    run_round();
    set_shape(15, 0, 9, 65535);
    run_round();
    set_shape(1, 8, 1, 65534);
    run_round();
    while (sent < 450) begin
      set_shape($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
                ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535));
      repeat ($urandom_range(1, 4)) run_round();
    end
    drain();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending_c.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
